// ----- hdl/rsi_indicator_trade_signal_core_assert.svh -----
// Assertion helpers shared by the RSI block modules.
// Both expect clk_i and rst_ni in scope.
`ifndef RSI_INDICATOR_TRADE_SIGNAL_CORE_ASSERT_SVH
`define RSI_INDICATOR_TRADE_SIGNAL_CORE_ASSERT_SVH

// Condition holds at every clock edge out of reset
`define RSI_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence holds in the cycle after the antecedent
`define RSI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/rsi_pkg.sv -----
package rsi_pkg;

  // Default sizing
  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int PRICE_BITS_DEF   = 17;

  // Fixed field widths
  localparam int TIME_W     = 18;
  localparam int CFG_DATA_W = 18;
  localparam int CFG_IDX_W  = 2;
  localparam int WLEN_CFG_W = 7;
  localparam int PCT_W      = 7;

  // Divider produces one quotient bit per step
  localparam int DIV_STEPS = PCT_W;

  // Queue depth between stages
  localparam int FIFO_DEPTH = 2;

  // Reset and limit values
  localparam int WLEN_RST = 14;
  localparam int WLEN_MIN = 2;
  localparam logic [TIME_W-1:0] SESSION_START_RST = 18'd91500;
  localparam logic [TIME_W-1:0] SESSION_END_RST   = 18'd161500;
  localparam int PRICE_CAP = 99999;

  // RSI scale and extreme thresholds
  localparam int PCT_SCALE = 100;
  localparam int RSI_HI    = 70;
  localparam int RSI_LO    = 30;

  // Price test against the window average: 1.1 and 0.9 as tenths
  localparam int AVG_SCALE  = 10;
  localparam int AVG_HI_NUM = 11;
  localparam int AVG_LO_NUM = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WLEN       = 2'd0,
    CFG_SESS_START = 2'd1,
    CFG_SESS_END   = 2'd2
  } rsi_cfg_idx_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_EVAL = 1'b1
  } rsi_cmd_e;

  typedef enum logic [1:0] {
    DEC_HOLD = 2'd0,
    DEC_SELL = 2'd1,
    DEC_BUY  = 2'd2
  } rsi_decision_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_OLD,
    ST_RD_SEC,
    ST_DROP,
    ST_ADD,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } rsi_state_e;

  typedef struct packed {
    logic [PCT_W-1:0] rsi_percent;
    logic             rsi_defined;
    logic             window_full;
    logic             tick_accepted;
    rsi_decision_e    decision;
  } rsi_result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rsi_fifo_stat_t;

endpackage

// ----- hdl/rsi_fifo.sv -----
`include "rsi_indicator_trade_signal_core_assert.svh"

module rsi_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_i,
  input  logic [WIDTH-1:0]      wr_data_i,
  input  logic                  rd_i,
  output logic [WIDTH-1:0]      rd_data_o,
  output rsi_pkg::rsi_fifo_stat_t stat_o
);

  localparam int PTR_W = $clog2(rsi_pkg::FIFO_DEPTH);
  localparam int CNT_W = $clog2(rsi_pkg::FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(rsi_pkg::FIFO_DEPTH - 1);

  logic [WIDTH-1:0] mem_q [rsi_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold the stored requests
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o    = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == CNT_W'(rsi_pkg::FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);

  `RSI_ASSERT_ALWAYS(a_fifo_cnt_range, cnt_q <= CNT_W'(rsi_pkg::FIFO_DEPTH), "fifo count out of range")
  `RSI_ASSERT_ALWAYS(a_fifo_no_overflow, !(wr_i && stat_o.full && !rd_i), "fifo write while full")
  `RSI_ASSERT_ALWAYS(a_fifo_no_underflow, !(rd_i && stat_o.empty), "fifo read while empty")

endmodule

// ----- hdl/rsi_front.sv -----
module rsi_front #(
  parameter int PRICE_BITS = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic                            command_i,
  input  logic [PRICE_BITS-1:0]           price_i,
  input  logic [rsi_pkg::TIME_W-1:0]      tick_time_i,
  input  rsi_pkg::rsi_fifo_stat_t         q_stat_i,
  output logic                            q_push_o,
  output logic [PRICE_BITS+1:0]           q_data_o
);

  logic [rsi_pkg::TIME_W-1:0] sess_start_q;
  logic [rsi_pkg::TIME_W-1:0] sess_end_q;
  logic [31:0]                price_ext;
  logic                       in_session;
  logic                       below_cap;
  logic                       tick_ok;

  // Hold session bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_start_q <= rsi_pkg::SESSION_START_RST;
      sess_end_q   <= rsi_pkg::SESSION_END_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsi_pkg::CFG_SESS_START: sess_start_q <= cfg_data_i[rsi_pkg::TIME_W-1:0];
        rsi_pkg::CFG_SESS_END:   sess_end_q   <= cfg_data_i[rsi_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the tick: session window and price cap
  assign price_ext  = 32'(price_i);
  assign in_session = (tick_time_i >= sess_start_q) && (tick_time_i <= sess_end_q);
  assign below_cap  = price_ext < 32'(rsi_pkg::PRICE_CAP);
  assign tick_ok    = (command_i == rsi_pkg::CMD_EVAL) && in_session && below_cap;

  // Forward accepted requests into the work queue
  assign full_o   = q_stat_i.full;
  assign q_push_o = push_i && !q_stat_i.full;
  assign q_data_o = {command_i, tick_ok, price_i};

endmodule

// ----- hdl/rsi_back.sv -----
`include "rsi_indicator_trade_signal_core_assert.svh"

module rsi_back #(
  parameter int WINDOW_DEPTH = rsi_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  rsi_pkg::rsi_fifo_stat_t         item_stat_i,
  input  logic [PRICE_BITS+1:0]           item_data_i,
  output logic                            item_pop_o,
  input  rsi_pkg::rsi_fifo_stat_t         res_stat_i,
  output logic                            res_push_o,
  output rsi_pkg::rsi_result_t            res_data_o
);

  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = PRICE_BITS + SLOT_W;
  localparam int TOT_W  = SUM_W + 1;
  localparam int PCT_W  = rsi_pkg::PCT_W;
  localparam int DIV_W  = SUM_W + PCT_W;
  localparam int PROD_W = PRICE_BITS + LEN_W;
  localparam int CMP_W  = PROD_W + 4;
  localparam int CNT_W  = $clog2(rsi_pkg::DIV_STEPS);
  localparam int LEN_RST_I = (rsi_pkg::WLEN_RST > WINDOW_DEPTH) ? WINDOW_DEPTH
                                                                 : rsi_pkg::WLEN_RST;

  rsi_pkg::rsi_state_e state_q, state_d;

  // Window bookkeeping
  logic [LEN_W-1:0]  len_q;
  logic [SLOT_W-1:0] ws_q;
  logic [LEN_W-1:0]  fill_q;
  logic [SUM_W-1:0]  rise_q;
  logic [SUM_W-1:0]  fall_q;
  logic [SUM_W-1:0]  csum_q;
  logic [CNT_W-1:0]  cnt_q;

  // Current request and datapath
  rsi_pkg::rsi_cmd_e      cmd_q;
  logic                   acc_q;
  logic [PRICE_BITS-1:0]  price_q;
  logic [PRICE_BITS-1:0]  last_q;
  logic [PRICE_BITS-1:0]  oldest_q;
  logic [PRICE_BITS-1:0]  rdata_q;
  logic [DIV_W-1:0]       rem_q;
  logic [DIV_W-1:0]       dsh_q;
  logic [PCT_W-1:0]       quo_q;
  logic [PROD_W-1:0]      prod_q;

  logic [PRICE_BITS-1:0] ring_q [WINDOW_DEPTH];

  logic [SLOT_W-1:0] ws_nxt;
  logic [SLOT_W-1:0] rd_addr;
  logic [TOT_W-1:0]  total;
  logic [31:0]       wlen_raw;
  logic [LEN_W-1:0]  len_cfg;
  rsi_pkg::rsi_cmd_e item_cmd;

  assign item_cmd = rsi_pkg::rsi_cmd_e'(item_data_i[PRICE_BITS+1]);
  assign total    = TOT_W'(rise_q) + TOT_W'(fall_q);
  assign ws_nxt   = ((LEN_W'(ws_q) + LEN_W'(1)) == len_q) ? '0 : ws_q + SLOT_W'(1);
  assign rd_addr  = (state_q == rsi_pkg::ST_RD_SEC) ? ws_nxt : ws_q;

  // Clamp the window length write
  assign wlen_raw = 32'(cfg_data_i[rsi_pkg::WLEN_CFG_W-1:0]);
  always_comb begin
    if (wlen_raw < 32'(rsi_pkg::WLEN_MIN)) begin
      len_cfg = LEN_W'(rsi_pkg::WLEN_MIN);
    end else if (wlen_raw > 32'(WINDOW_DEPTH)) begin
      len_cfg = LEN_W'(WINDOW_DEPTH);
    end else begin
      len_cfg = LEN_W'(wlen_raw);
    end
  end

  // Sequencer: next state and handshake strobes
  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    res_push_o = 1'b0;
    case (state_q)
      rsi_pkg::ST_IDLE: begin
        if (!item_stat_i.empty) begin
          item_pop_o = 1'b1;
          if (item_cmd == rsi_pkg::CMD_EVAL) begin
            state_d = rsi_pkg::ST_DIV_INIT;
          end else if (fill_q >= len_q) begin
            state_d = rsi_pkg::ST_RD_OLD;
          end else begin
            state_d = rsi_pkg::ST_ADD;
          end
        end
      end
      rsi_pkg::ST_RD_OLD:   state_d = rsi_pkg::ST_RD_SEC;
      rsi_pkg::ST_RD_SEC:   state_d = rsi_pkg::ST_DROP;
      rsi_pkg::ST_DROP:     state_d = rsi_pkg::ST_ADD;
      rsi_pkg::ST_ADD:      state_d = rsi_pkg::ST_DIV_INIT;
      rsi_pkg::ST_DIV_INIT: state_d = rsi_pkg::ST_DIV;
      rsi_pkg::ST_DIV: begin
        if (cnt_q == '0) begin
          state_d = rsi_pkg::ST_FIN;
        end
      end
      rsi_pkg::ST_FIN: begin
        if (!res_stat_i.full) begin
          res_push_o = 1'b1;
          state_d    = rsi_pkg::ST_IDLE;
        end
      end
      default: state_d = rsi_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsi_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Window sums, slot and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= LEN_W'(LEN_RST_I);
      ws_q   <= '0;
      fill_q <= '0;
      rise_q <= '0;
      fall_q <= '0;
      csum_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i && (cfg_idx_i == rsi_pkg::CFG_WLEN)) begin
      // new length empties the window
      len_q  <= len_cfg;
      ws_q   <= '0;
      fill_q <= '0;
      rise_q <= '0;
      fall_q <= '0;
      csum_q <= '0;
    end else begin
      case (state_q)
        rsi_pkg::ST_DROP: begin
          // drop the oldest close and its move to the next one
          csum_q <= csum_q - SUM_W'(oldest_q);
          if (oldest_q > rdata_q) begin
            fall_q <= fall_q - SUM_W'(oldest_q - rdata_q);
          end else begin
            rise_q <= rise_q - SUM_W'(rdata_q - oldest_q);
          end
          fill_q <= len_q - LEN_W'(1);
        end
        rsi_pkg::ST_ADD: begin
          // add the move from the newest close to this one
          if (fill_q != '0) begin
            if (last_q > price_q) begin
              fall_q <= fall_q + SUM_W'(last_q - price_q);
            end else begin
              rise_q <= rise_q + SUM_W'(price_q - last_q);
            end
          end
          csum_q <= csum_q + SUM_W'(price_q);
          fill_q <= fill_q + LEN_W'(1);
          ws_q   <= ws_nxt;
        end
        rsi_pkg::ST_DIV_INIT: cnt_q <= CNT_W'(rsi_pkg::DIV_STEPS - 1);
        rsi_pkg::ST_DIV:      cnt_q <= cnt_q - CNT_W'(1);
        default: ;
      endcase
    end
  end

  // Close ring: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == rsi_pkg::ST_ADD) begin
      ring_q[ws_q] <= price_q;
    end
    rdata_q <= ring_q[rd_addr];
  end

  // Request capture and restoring divider
  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      cmd_q   <= item_cmd;
      acc_q   <= item_data_i[PRICE_BITS];
      price_q <= item_data_i[PRICE_BITS-1:0];
    end
    case (state_q)
      rsi_pkg::ST_RD_SEC: oldest_q <= rdata_q;
      rsi_pkg::ST_ADD:    last_q   <= price_q;
      rsi_pkg::ST_DIV_INIT: begin
        rem_q  <= DIV_W'(rise_q) * DIV_W'(rsi_pkg::PCT_SCALE);
        dsh_q  <= DIV_W'(total) << (PCT_W - 1);
        quo_q  <= '0;
        prod_q <= PROD_W'(price_q) * PROD_W'(len_q);
      end
      rsi_pkg::ST_DIV: begin
        if (rem_q >= dsh_q) begin
          rem_q <= rem_q - dsh_q;
          quo_q <= {quo_q[PCT_W-2:0], 1'b1};
        end else begin
          quo_q <= {quo_q[PCT_W-2:0], 1'b0};
        end
        dsh_q <= dsh_q >> 1;
      end
      default: ;
    endcase
  end

  // Form the result from quotient, remainder and price product
  logic             win_full;
  logic             defined;
  logic             rsi_high;
  logic             rsi_low;
  logic [CMP_W-1:0] lhs;
  logic [CMP_W-1:0] hi_ref;
  logic [CMP_W-1:0] lo_ref;

  assign win_full = (fill_q == len_q);
  assign defined  = (total != '0);
  assign rsi_high = (quo_q > PCT_W'(rsi_pkg::RSI_HI)) ||
                    ((quo_q == PCT_W'(rsi_pkg::RSI_HI)) && (rem_q != '0));
  assign rsi_low  = (quo_q < PCT_W'(rsi_pkg::RSI_LO));
  assign lhs      = CMP_W'(prod_q) * CMP_W'(rsi_pkg::AVG_SCALE);
  assign hi_ref   = CMP_W'(csum_q) * CMP_W'(rsi_pkg::AVG_HI_NUM);
  assign lo_ref   = CMP_W'(csum_q) * CMP_W'(rsi_pkg::AVG_LO_NUM);

  always_comb begin
    res_data_o.rsi_percent   = defined ? quo_q : '0;
    res_data_o.rsi_defined   = defined;
    res_data_o.window_full   = win_full;
    res_data_o.tick_accepted = (cmd_q == rsi_pkg::CMD_EVAL) && acc_q;
    res_data_o.decision      = rsi_pkg::DEC_HOLD;
    if ((cmd_q == rsi_pkg::CMD_EVAL) && acc_q && win_full && defined &&
        (rsi_high || rsi_low)) begin
      if (lhs > hi_ref) begin
        res_data_o.decision = rsi_pkg::DEC_SELL;
      end else if (lhs < lo_ref) begin
        res_data_o.decision = rsi_pkg::DEC_BUY;
      end
    end
  end

  `RSI_ASSERT_ALWAYS(a_fill_le_len, fill_q <= len_q, "fill count exceeds window length")
  `RSI_ASSERT_ALWAYS(a_slot_lt_len, LEN_W'(ws_q) < len_q, "write slot outside window")
  `RSI_ASSERT_NEXT(a_div_ends, (state_q == rsi_pkg::ST_DIV) && (cnt_q == '0), state_q == rsi_pkg::ST_FIN, "divider did not finish")

endmodule

// ----- hdl/rsi_indicator_trade_signal_core.sv -----
// Flow: each request passes the work queue, the back-end sequencer and the result queue;
//   a close pushed into a full window first drops the oldest close from the sums.
// The back end takes a new request only after it has pushed the last result; each runs
//   the seven-step RSI divider, and a rolling window adds two reads of the close ring.
// Reset (rst_ni low, asynchronous): queues empty, window empty, length 14,
//   session 91500 to 161500; the close ring itself is not cleared.
module rsi_indicator_trade_signal_core #(
  parameter int WINDOW_DEPTH = rsi_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = rsi_pkg::PRICE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rsi_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rsi_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic                            command_i,
  input  logic [PRICE_BITS-1:0]           price_i,
  input  logic [rsi_pkg::TIME_W-1:0]      tick_time_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [rsi_pkg::PCT_W-1:0]       rsi_percent_o,
  output logic                            rsi_defined_o,
  output logic                            window_full_o,
  output logic                            tick_accepted_o,
  output logic [1:0]                      decision_o
);

  localparam int ITEM_W = PRICE_BITS + 2;
  localparam int RES_W  = $bits(rsi_pkg::rsi_result_t);

  rsi_pkg::rsi_fifo_stat_t item_stat;
  rsi_pkg::rsi_fifo_stat_t res_stat;
  logic                    item_wr;
  logic [ITEM_W-1:0]       item_wdata;
  logic [ITEM_W-1:0]       item_rdata;
  logic                    item_rd;
  logic                    res_wr;
  rsi_pkg::rsi_result_t    res_wdata;
  logic [RES_W-1:0]        res_rdata;
  rsi_pkg::rsi_result_t    res_out;
  logic                    res_rd;

  // Accept and classify requests
  rsi_front #(
    .PRICE_BITS (PRICE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .full_o      (full),
    .command_i   (command_i),
    .price_i     (price_i),
    .tick_time_i (tick_time_i),
    .q_stat_i    (item_stat),
    .q_push_o    (item_wr),
    .q_data_o    (item_wdata)
  );

  // Work queue between front and back
  rsi_fifo #(
    .WIDTH (ITEM_W)
  ) u_item_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (item_wr),
    .wr_data_i (item_wdata),
    .rd_i      (item_rd),
    .rd_data_o (item_rdata),
    .stat_o    (item_stat)
  );

  // Window update, RSI division and decision
  rsi_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .PRICE_BITS   (PRICE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_stat_i (item_stat),
    .item_data_i (item_rdata),
    .item_pop_o  (item_rd),
    .res_stat_i  (res_stat),
    .res_push_o  (res_wr),
    .res_data_o  (res_wdata)
  );

  // Result queue toward the consumer
  rsi_fifo #(
    .WIDTH (RES_W)
  ) u_res_q (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_wr),
    .wr_data_i (RES_W'(res_wdata)),
    .rd_i      (res_rd),
    .rd_data_o (res_rdata),
    .stat_o    (res_stat)
  );

  assign res_rd          = pop && !res_stat.empty;
  assign empty           = res_stat.empty;
  assign res_out         = rsi_pkg::rsi_result_t'(res_rdata);
  assign rsi_percent_o   = res_out.rsi_percent;
  assign rsi_defined_o   = res_out.rsi_defined;
  assign window_full_o   = res_out.window_full;
  assign tick_accepted_o = res_out.tick_accepted;
  assign decision_o      = 2'(res_out.decision);

endmodule

// ----- dv/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW             = rsi_pkg::PRICE_BITS_DEF;
  localparam int DEPTH          = rsi_pkg::WINDOW_DEPTH_DEF;
  localparam int TW             = rsi_pkg::TIME_W;
  localparam int CW             = rsi_pkg::CFG_DATA_W;
  localparam int PCTW           = rsi_pkg::PCT_W;
  localparam int PRICE_MAX      = (1 << PW) - 1;
  localparam int TIME_MAX       = 235959;
  localparam int IN_SESSION     = 120000;
  localparam int STALL_CYCLES   = 250;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 58;

  // Index with no register behind it
  localparam logic [rsi_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct {
    rsi_pkg::rsi_cmd_e cmd;
    logic [PW-1:0]     price;
    logic [TW-1:0]     tick_time;
  } order_t;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          cfg_we_i   = 1'b0;
  logic [rsi_pkg::CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CW-1:0]                 cfg_data_i = '0;
  logic                          push       = 1'b0;
  logic                          full;
  logic                          command_i   = 1'b0;
  logic [PW-1:0]                 price_i     = '0;
  logic [TW-1:0]                 tick_time_i = '0;
  logic                          empty;
  logic                          pop         = 1'b0;
  logic [PCTW-1:0]               rsi_percent_o;
  logic                          rsi_defined_o;
  logic                          window_full_o;
  logic                          tick_accepted_o;
  logic [1:0]                    decision_o;

  // Shadow copy of the window and the registers
  logic [PW-1:0]         close_ring_m [DEPTH];
  int unsigned           slot_m;
  int unsigned           fill_m;
  int unsigned           len_m;
  longint unsigned       rise_sum_m;
  longint unsigned       fall_sum_m;
  longint unsigned       close_sum_m;
  logic [TW-1:0]         sess_start_m;
  logic [TW-1:0]         sess_end_m;

  order_t                queued_orders [$];
  rsi_pkg::rsi_result_t  awaited_signals [$];
  order_t                next_order;
  rsi_pkg::rsi_result_t  want;

  int unsigned           mismatches = 0;
  int unsigned           send_gap_max = 0;
  int unsigned           recv_gap_max = 0;
  int unsigned           send_wait;
  int unsigned           recv_wait;
  int unsigned           stall_left;
  int unsigned           stall_id = 0;
  int unsigned           stall_seen;
  int unsigned           idle_cycles;

  rsi_indicator_trade_signal_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .command_i       (command_i),
    .price_i         (price_i),
    .tick_time_i     (tick_time_i),
    .empty           (empty),
    .pop             (pop),
    .rsi_percent_o   (rsi_percent_o),
    .rsi_defined_o   (rsi_defined_o),
    .window_full_o   (window_full_o),
    .tick_accepted_o (tick_accepted_o),
    .decision_o      (decision_o)
  );

  always #5ns clk_i = ~clk_i;

  // Drop every close and movement from the shadow window
  function automatic void empty_window();
    slot_m      = 0;
    fill_m      = 0;
    rise_sum_m  = 0;
    fall_sum_m  = 0;
    close_sum_m = 0;
  endfunction

  // Advance the shadow window by one request and work out its signal
  function automatic rsi_pkg::rsi_result_t compute_signal(rsi_pkg::rsi_cmd_e cmd,
                                                          logic [PW-1:0] px,
                                                          logic [TW-1:0] t);
    rsi_pkg::rsi_result_t res;
    longint unsigned      oldest, second, newest, rise, fall, total, lhs;
    int unsigned          slot, len;
    res  = '0;
    slot = slot_m;
    len  = len_m;
    if (cmd == rsi_pkg::CMD_PUSH) begin
      // Retire the oldest close and its move once the window is full
      if (fill_m >= len) begin
        oldest = 64'(close_ring_m[slot]);
        second = 64'(close_ring_m[(slot + 1) % len]);
        close_sum_m -= oldest;
        if (oldest > second) fall_sum_m -= oldest - second;
        else rise_sum_m -= second - oldest;
        fill_m = len - 1;
      end
      if (fill_m > 0) begin
        newest = 64'(close_ring_m[(slot + len - 1) % len]);
        if (newest > 64'(px)) fall_sum_m += newest - 64'(px);
        else rise_sum_m += 64'(px) - newest;
      end
      close_ring_m[slot] = px;
      close_sum_m += 64'(px);
      fill_m++;
      slot_m = (slot + 1) % len;
    end
    rise  = rise_sum_m;
    fall  = fall_sum_m;
    total = rise + fall;
    res.rsi_defined = (total != 0);
    if (res.rsi_defined) res.rsi_percent = PCTW'((rsi_pkg::PCT_SCALE * rise) / total);
    res.window_full = (fill_m == len_m);
    if (cmd == rsi_pkg::CMD_EVAL) begin
      res.tick_accepted = (t >= sess_start_m) && (t <= sess_end_m) &&
                          (px < rsi_pkg::PRICE_CAP);
      // Compare the RSI and the average exactly by cross-multiplication
      if (res.tick_accepted && res.window_full && res.rsi_defined &&
          ((rsi_pkg::PCT_SCALE * rise > rsi_pkg::RSI_HI * total) ||
           (rsi_pkg::PCT_SCALE * rise < rsi_pkg::RSI_LO * total))) begin
        lhs = rsi_pkg::AVG_SCALE * 64'(px) * len;
        if (lhs > rsi_pkg::AVG_HI_NUM * close_sum_m) res.decision = rsi_pkg::DEC_SELL;
        else if (lhs < rsi_pkg::AVG_LO_NUM * close_sum_m) res.decision = rsi_pkg::DEC_BUY;
      end
    end
    return res;
  endfunction

  task automatic add_order(rsi_pkg::rsi_cmd_e cmd, int unsigned px, int unsigned t);
    order_t o;
    o.cmd       = cmd;
    o.price     = PW'(px);
    o.tick_time = TW'(t);
    queued_orders = {queued_orders, o};
  endtask

  // Write one register while idle and mirror it in the shadow copy
  task automatic write_reg(logic [rsi_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    int unsigned wl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CW'(data);
    case (idx)
      rsi_pkg::CFG_WLEN: begin
        wl = 32'(data[rsi_pkg::WLEN_CFG_W-1:0]);
        if (wl < rsi_pkg::WLEN_MIN) wl = rsi_pkg::WLEN_MIN;
        if (wl > DEPTH) wl = DEPTH;
        len_m = wl;
        empty_window();
      end
      rsi_pkg::CFG_SESS_START: sess_start_m = TW'(data);
      rsi_pkg::CFG_SESS_END: sess_end_m = TW'(data);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every request is sent and answered, then let the pipe drain
  task automatic settle();
    while (queued_orders.size() != 0 || push || awaited_signals.size() != 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Trending runs of closes followed by ticks, mixed with raw noise
  task automatic random_phase(int unsigned n_items);
    int unsigned       made, npush, neval, pct, px;
    int                level, delta;
    bit                rising;
    logic [TW-1:0]     t;
    @(negedge clk_i);
    made = 0;
    while (made < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        level  = $urandom_range(100, 100000);
        rising = $urandom_range(0, 1);
        npush  = $urandom_range(1, len_m + 2);
        repeat (npush) begin
          delta = $urandom_range(0, 400);
          if ($urandom_range(0, 99) < 15) level = rising ? level - delta : level + delta;
          else level = rising ? level + delta : level - delta;
          if (level < 0) level = 0;
          if (level > PRICE_MAX) level = PRICE_MAX;
          add_order(rsi_pkg::CMD_PUSH, unsigned'(level), $urandom_range(0, TIME_MAX));
        end
        neval = $urandom_range(1, 4);
        repeat (neval) begin
          pct = $urandom_range(40, 160);
          px  = unsigned'(level) * pct / 100;
          if (px > PRICE_MAX) px = PRICE_MAX;
          if ($urandom_range(0, 19) == 0)
            px = $urandom_range(rsi_pkg::PRICE_CAP - 2, rsi_pkg::PRICE_CAP + 2);
          if (sess_start_m <= sess_end_m && $urandom_range(0, 9) < 9)
            t = TW'($urandom_range(sess_start_m, sess_end_m));
          else
            t = TW'($urandom_range(0, TIME_MAX));
          add_order(rsi_pkg::CMD_EVAL, px, t);
        end
        made += npush + neval;
      end else begin
        add_order(rsi_pkg::rsi_cmd_e'($urandom_range(0, 1)), $urandom_range(0, PRICE_MAX),
                  $urandom_range(0, TIME_MAX));
        made++;
      end
    end
  endtask

  // Request driver: offer queued items, idle a random gap after each one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push        <= 1'b0;
      command_i   <= rsi_pkg::CMD_PUSH;
      price_i     <= '0;
      tick_time_i <= '0;
      send_wait    = 0;
    end else begin
      if (push && !full) begin
        awaited_signals = {awaited_signals,
                           compute_signal(rsi_pkg::rsi_cmd_e'(command_i), price_i,
                                          tick_time_i)};
        send_wait = $urandom_range(0, send_gap_max);
      end
      if (push && full) begin
        // hold the request until the block takes it
      end else if (send_wait != 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (queued_orders.size() != 0) begin
        next_order   = queued_orders.pop_front();
        push        <= 1'b1;
        command_i   <= next_order.cmd;
        price_i     <= next_order.price;
        tick_time_i <= next_order.tick_time;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: check each popped result, idle and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      recv_wait   = 0;
      stall_left  = 0;
      stall_seen  = 0;
    end else begin
      if (pop && !empty) begin
        if (awaited_signals.size() == 0) begin
          $error("result with no request awaiting it");
          mismatches++;
        end else begin
          want = awaited_signals.pop_front();
          if (rsi_percent_o !== want.rsi_percent) begin
            $error("rsi_percent: expected %0d, got %0d", want.rsi_percent, rsi_percent_o);
            mismatches++;
          end
          if (rsi_defined_o !== want.rsi_defined) begin
            $error("rsi_defined: expected %0d, got %0d", want.rsi_defined, rsi_defined_o);
            mismatches++;
          end
          if (window_full_o !== want.window_full) begin
            $error("window_full: expected %0d, got %0d", want.window_full, window_full_o);
            mismatches++;
          end
          if (tick_accepted_o !== want.tick_accepted) begin
            $error("tick_accepted: expected %0d, got %0d", want.tick_accepted, tick_accepted_o);
            mismatches++;
          end
          if (decision_o !== want.decision) begin
            $error("decision: expected %0d, got %0d", want.decision, decision_o);
            mismatches++;
          end
        end
        recv_wait = $urandom_range(0, recv_gap_max);
      end
      if (stall_id != stall_seen) begin
        stall_seen = stall_id;
        stall_left = STALL_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (recv_wait != 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no request moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    len_m        = rsi_pkg::WLEN_RST;
    sess_start_m = rsi_pkg::SESSION_START_RST;
    sess_end_m   = rsi_pkg::SESSION_END_RST;
    empty_window();
    send_gap_max = 5;
    recv_gap_max = 5;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Short window: empty, exactly 70, falls only, prices above, below and inside the band, session edges, cap
    write_reg(rsi_pkg::CFG_WLEN, 3);
    @(negedge clk_i);
    add_order(rsi_pkg::CMD_EVAL, 500, IN_SESSION);
    add_order(rsi_pkg::CMD_PUSH, 100, 0);
    add_order(rsi_pkg::CMD_PUSH, 107, TIME_MAX);
    add_order(rsi_pkg::CMD_PUSH, 104, 0);
    add_order(rsi_pkg::CMD_EVAL, 200, IN_SESSION);
    add_order(rsi_pkg::CMD_PUSH, 101, 0);
    add_order(rsi_pkg::CMD_EVAL, 200, IN_SESSION);
    add_order(rsi_pkg::CMD_EVAL, 50, IN_SESSION);
    add_order(rsi_pkg::CMD_EVAL, 104, IN_SESSION);
    add_order(rsi_pkg::CMD_EVAL, rsi_pkg::PRICE_CAP - 1, rsi_pkg::SESSION_START_RST);
    add_order(rsi_pkg::CMD_EVAL, 50, rsi_pkg::SESSION_START_RST - 1);
    add_order(rsi_pkg::CMD_EVAL, 50, rsi_pkg::SESSION_END_RST);
    add_order(rsi_pkg::CMD_EVAL, 50, rsi_pkg::SESSION_END_RST + 1);
    add_order(rsi_pkg::CMD_EVAL, rsi_pkg::PRICE_CAP, IN_SESSION);
    // Flat window, then price extremes
    add_order(rsi_pkg::CMD_PUSH, 101, 0);
    add_order(rsi_pkg::CMD_PUSH, 101, 0);
    add_order(rsi_pkg::CMD_EVAL, 50, IN_SESSION);
    add_order(rsi_pkg::CMD_PUSH, 0, 0);
    add_order(rsi_pkg::CMD_PUSH, PRICE_MAX, 0);
    add_order(rsi_pkg::CMD_EVAL, 0, 0);
    add_order(rsi_pkg::CMD_EVAL, 0, IN_SESSION);
    settle();

    // Widest session, then the shortest window with rises only
    write_reg(rsi_pkg::CFG_SESS_START, 0);
    write_reg(rsi_pkg::CFG_SESS_END, TIME_MAX);
    @(negedge clk_i);
    add_order(rsi_pkg::CMD_EVAL, PRICE_MAX, TIME_MAX);
    add_order(rsi_pkg::CMD_EVAL, 0, 0);
    settle();
    write_reg(rsi_pkg::CFG_WLEN, 0);
    @(negedge clk_i);
    add_order(rsi_pkg::CMD_PUSH, 5, 0);
    add_order(rsi_pkg::CMD_PUSH, 9, 0);
    add_order(rsi_pkg::CMD_EVAL, 20, 100000);
    settle();

    // Inverted session rejects every tick
    write_reg(rsi_pkg::CFG_SESS_START, 200000);
    write_reg(rsi_pkg::CFG_SESS_END, 100000);
    @(negedge clk_i);
    add_order(rsi_pkg::CMD_EVAL, 9, 150000);
    settle();
    write_reg(CFG_IDX_SPARE, 18'h15555);
    write_reg(rsi_pkg::CFG_WLEN, 18'h3FFFF);

    // Random phases over several settings
    for (int i = 0; i < RANDOM_PHASES; i++) begin
      settle();
      case (i)
        1: write_reg(rsi_pkg::CFG_WLEN, 2);
        2: write_reg(rsi_pkg::CFG_WLEN, 65);
        default: write_reg(rsi_pkg::CFG_WLEN,
                           ($urandom_range(0, 2047) << rsi_pkg::WLEN_CFG_W) |
                           $urandom_range(2, 20));
      endcase
      case (i)
        3: begin
          write_reg(rsi_pkg::CFG_SESS_START, 0);
          write_reg(rsi_pkg::CFG_SESS_END, TIME_MAX);
        end
        5: begin
          write_reg(rsi_pkg::CFG_SESS_START, $urandom_range(0, TIME_MAX));
          write_reg(rsi_pkg::CFG_SESS_END, $urandom_range(0, TIME_MAX));
        end
        default: begin
          write_reg(rsi_pkg::CFG_SESS_START, $urandom_range(0, IN_SESSION));
          write_reg(rsi_pkg::CFG_SESS_END, $urandom_range(IN_SESSION, TIME_MAX));
        end
      endcase
      if (i == 4 || i % 3 == 0) begin
        send_gap_max = 0;
        recv_gap_max = 0;
      end else begin
        send_gap_max = 5;
        recv_gap_max = 5;
      end
      // Stall the receiver while the sender keeps offering
      if (i == 4) @(posedge clk_i) stall_id <= stall_id + 1;
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
